@@ sv/scc_pkg.sv @@
package scc_pkg;

  localparam int NUM_REGIONS = 7;
  localparam int MAX_SAMPLES = 256;

  localparam int NUM_CH     = 3;
  localparam int CH_W       = 8;
  localparam int REG_W      = 3;
  localparam int BIN_W      = CH_W;
  localparam int HIST_DEPTH = 2 ** BIN_W;
  localparam int WALK_W     = BIN_W + 1;
  localparam int CNT_W      = $clog2(MAX_SAMPLES + 1);

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = Q_PTR_W + 1;

  // configuration port
  localparam int NUM_CFG  = 6;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;
  localparam int CFG_IDX_W = ADDR_W - 2;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_C0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_C1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_C2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_C0 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_C1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_C2 = 3'd5;

  localparam logic [NUM_CH-1:0][CH_W-1:0] LOW_MARGIN_RST  = {8'd20, 8'd30, 8'd20};
  localparam logic [NUM_CH-1:0][CH_W-1:0] HIGH_MARGIN_RST = {8'd80, 8'd40, 8'd20};

  // input op and result kind codes
  localparam logic OP_CALIB    = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;
  localparam logic RES_MASK    = 1'b0;
  localparam logic RES_MEDIAN  = 1'b1;

  typedef enum logic [1:0] {
    CMD_CLASSIFY,
    CMD_SAMPLE,
    CMD_FINISH
  } cmd_e;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_INC,
    BK_WALK,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    cmd_e                           kind;
    logic [REG_W-1:0]               region;
    logic [NUM_CH-1:0][CH_W-1:0]    px;
  } scc_cmd_t;

  typedef struct packed {
    logic [NUM_CH-1:0][CH_W-1:0] lo;
    logic [NUM_CH-1:0][CH_W-1:0] hi;
  } scc_margin_t;

  typedef struct packed {
    logic                        kind;
    logic                        mask;
    logic [NUM_CH-1:0][CH_W-1:0] med;
  } scc_res_t;

  // px inside [med - lo, med + hi], clamped to the 8-bit range
  function automatic logic in_box(input logic [NUM_CH-1:0][CH_W-1:0] med,
                                  input scc_margin_t mg,
                                  input logic [NUM_CH-1:0][CH_W-1:0] px);
    logic ok;
    logic [CH_W:0] px_lo;
    logic [CH_W:0] up;
    ok = 1'b1;
    for (int c = 0; c < NUM_CH; c++) begin
      px_lo = {1'b0, px[c]} + {1'b0, mg.lo[c]};
      up    = {1'b0, med[c]} + {1'b0, mg.hi[c]};
      if (px_lo < {1'b0, med[c]}) ok = 1'b0;
      if ({1'b0, px[c]} > up) ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

@@ sv/scc_in_if.sv @@
interface scc_in_if import scc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             op;
  logic [REG_W-1:0] region;
  logic [CH_W-1:0]  chan0;
  logic [CH_W-1:0]  chan1;
  logic [CH_W-1:0]  chan2;
  logic             last_sample;

  modport source (output valid, op, region, chan0, chan1, chan2, last_sample, input ready);
  modport sink (input valid, op, region, chan0, chan1, chan2, last_sample, output ready);
endinterface

@@ sv/scc_out_if.sv @@
interface scc_out_if import scc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            result_kind;
  logic            pixel_mask;
  logic [CH_W-1:0] median_c0;
  logic [CH_W-1:0] median_c1;
  logic [CH_W-1:0] median_c2;

  modport source (output valid, result_kind, pixel_mask, median_c0, median_c1, median_c2,
                  input ready);
  modport sink (input valid, result_kind, pixel_mask, median_c0, median_c1, median_c2,
                output ready);
endinterface

@@ sv/scc_front.sv @@
module scc_front import scc_pkg::*; (
  scc_in_if.sink   pix_i,
  input  logic     clearing_i,
  input  logic     q_full_i,
  output logic     push_o,
  output scc_cmd_t cmd_o
);

  assign pix_i.ready = !clearing_i && !q_full_i;
  assign push_o      = pix_i.valid && pix_i.ready;

  always_comb begin
    cmd_o.region = pix_i.region;
    cmd_o.px     = {pix_i.chan2, pix_i.chan1, pix_i.chan0};
    unique case (pix_i.op)
      OP_CLASSIFY: cmd_o.kind = CMD_CLASSIFY;
      OP_CALIB:    cmd_o.kind = pix_i.last_sample ? CMD_FINISH : CMD_SAMPLE;
      default:     cmd_o.kind = CMD_CLASSIFY;
    endcase
  end

endmodule

@@ sv/scc_queue.sv @@
module scc_queue import scc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  scc_cmd_t data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output scc_cmd_t head_o
);

  scc_cmd_t             slots_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0]   cnt_q;

  assign full_o  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slots_q[wr_ptr_q] <= data_i;
  end

endmodule

@@ sv/scc_back.sv @@
module scc_back import scc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  scc_cmd_t    q_head_i,
  output logic        q_pop_o,
  input  scc_margin_t margin_i,
  output scc_res_t    res_o,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic        clearing_o
);

  back_state_e state_q, state_d;
  logic [WALK_W-1:0] walk_q, walk_d;
  logic [CNT_W-1:0]  count_q, count_d;
  scc_cmd_t          cur_q, cur_d;
  logic [NUM_CH-1:0][CNT_W-1:0] seen_q, seen_d;
  logic [NUM_CH-1:0]            found_q, found_d;
  logic [NUM_CH-1:0][CH_W-1:0]  med_q, med_d;
  logic [NUM_REGIONS-1:0][NUM_CH-1:0][CH_W-1:0] rmed_q, rmed_d;
  scc_res_t res_q, res_d;
  logic     res_valid_q, res_valid_d;

  logic [NUM_CH-1:0][BIN_W-1:0] rd_addr, wr_addr;
  logic [NUM_CH-1:0][CNT_W-1:0] wr_data;
  logic [CNT_W-1:0]             rdata_q [NUM_CH];
  logic                         wr_en;
  logic                         slot_free;
  logic                         mask;
  logic [CNT_W-1:0]             target;
  logic [BIN_W-1:0]             bin;

  assign slot_free   = !res_valid_q || res_ready_i;
  assign target      = (count_q - CNT_W'(1)) >> 1;
  assign bin         = walk_q[BIN_W-1:0] - BIN_W'(1);
  assign clearing_o  = (state_q == BK_CLEAR);
  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

  always_comb begin
    mask = 1'b0;
    for (int r = 0; r < NUM_REGIONS; r++) begin
      if (in_box(rmed_q[r], margin_i, q_head_i.px)) mask = 1'b1;
    end
  end

  always_comb begin
    state_d     = state_q;
    walk_d      = walk_q;
    count_d     = count_q;
    cur_d       = cur_q;
    seen_d      = seen_q;
    found_d     = found_q;
    med_d       = med_q;
    rmed_d      = rmed_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !res_ready_i;
    q_pop_o     = 1'b0;
    wr_en       = 1'b0;
    for (int c = 0; c < NUM_CH; c++) begin
      rd_addr[c] = q_head_i.px[c];
      wr_addr[c] = walk_q[BIN_W-1:0];
      wr_data[c] = '0;
    end

    unique case (state_q)
      BK_CLEAR: begin
        wr_en  = 1'b1;
        walk_d = walk_q + 1'b1;
        if (walk_q[BIN_W-1:0] == '1) begin
          walk_d  = '0;
          state_d = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (q_valid_i) begin
          unique case (q_head_i.kind)
            CMD_CLASSIFY: begin
              if (slot_free) begin
                q_pop_o     = 1'b1;
                res_d.kind  = RES_MASK;
                res_d.mask  = mask;
                res_d.med   = '0;
                res_valid_d = 1'b1;
              end
            end
            CMD_SAMPLE, CMD_FINISH: begin
              q_pop_o = 1'b1;
              cur_d   = q_head_i;
              walk_d  = '0;
              if (count_q < CNT_W'(MAX_SAMPLES)) state_d = BK_INC;
              else if (q_head_i.kind == CMD_FINISH) state_d = BK_WALK;
            end
            default: ;
          endcase
        end
      end
      BK_INC: begin
        wr_en = 1'b1;
        for (int c = 0; c < NUM_CH; c++) begin
          wr_addr[c] = cur_q.px[c];
          wr_data[c] = rdata_q[c] + CNT_W'(1);
        end
        count_d = count_q + CNT_W'(1);
        state_d = (cur_q.kind == CMD_FINISH) ? BK_WALK : BK_IDLE;
      end
      BK_WALK: begin
        wr_en  = !walk_q[BIN_W];
        walk_d = walk_q + 1'b1;
        for (int c = 0; c < NUM_CH; c++) rd_addr[c] = walk_q[BIN_W-1:0];
        if (walk_q == '0) begin
          seen_d  = '0;
          found_d = '0;
          med_d   = '0;
        end else begin
          for (int c = 0; c < NUM_CH; c++) begin
            seen_d[c] = seen_q[c] + rdata_q[c];
            if (!found_q[c] && (seen_d[c] > target)) begin
              found_d[c] = 1'b1;
              med_d[c]   = bin;
            end
          end
        end
        if (walk_q[BIN_W]) state_d = BK_DONE;
      end
      BK_DONE: begin
        if (slot_free) begin
          res_d.kind  = RES_MEDIAN;
          res_d.mask  = 1'b0;
          res_d.med   = (count_q == '0) ? '0 : med_q;
          res_valid_d = 1'b1;
          for (int r = 0; r < NUM_REGIONS; r++) begin
            if (cur_q.region == REG_W'(r)) rmed_d[r] = res_d.med;
          end
          count_d = '0;
          walk_d  = '0;
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_CLEAR;
      walk_q      <= '0;
      count_q     <= '0;
      rmed_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      walk_q      <= walk_d;
      count_q     <= count_d;
      rmed_q      <= rmed_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    seen_q  <= seen_d;
    found_q <= found_d;
    med_q   <= med_d;
    res_q   <= res_d;
  end

  // one histogram per channel, read-first so a walk can read and clear a bin together
  for (genvar c = 0; c < NUM_CH; c++) begin : g_hist
    logic [CNT_W-1:0] hist_mem [HIST_DEPTH];
    always_ff @(posedge clk_i) begin
      rdata_q[c] <= hist_mem[rd_addr[c]];
      if (wr_en) hist_mem[wr_addr[c]] <= wr_data[c];
    end
  end

endmodule

@@ sv/hls_skin_calibrate_classify.sv @@
// channel   dir  handshake            payload
// pix_i     in   valid/ready          op, region, chan0..chan2, last_sample
// res_o     out  valid/ready          result_kind, pixel_mask, median_c0..median_c2
// apb       in   psel/penable/pready  paddr, pwdata, prdata (six 8-bit margin registers)
//
// a classified pixel is handled in the back end's idle state (all region boxes compared
// at once), so pixels stream at one per cycle while res_o takes results; a calibration
// sample passes the idle and increment states (histogram read-modify-write through the
// registered memory port); a finishing sample adds the walk over the 256 bins, which
// clears each bin as it reads it. after reset the histograms are swept to zero with
// pix_i.ready low; apb writes are taken throughout. a four-entry queue between front and
// back and the result register let input keep flowing while a result waits on res_o.ready
module hls_skin_calibrate_classify import scc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  scc_in_if.sink            pix_i,
  scc_out_if.source         res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // margin registers
  logic [NUM_CH-1:0][CH_W-1:0] low_q, high_q;
  logic [CFG_IDX_W-1:0]        cfg_idx;
  logic                        cfg_wr;
  scc_margin_t                 margin;

  // front to queue to back
  logic     q_push, q_full, q_pop, q_valid, clearing;
  scc_cmd_t q_in, q_head;
  scc_res_t res;
  logic     res_valid;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= LOW_MARGIN_RST;
      high_q <= HIGH_MARGIN_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_LOW_C0:  low_q[0]  <= pwdata[CH_W-1:0];
        REG_LOW_C1:  low_q[1]  <= pwdata[CH_W-1:0];
        REG_LOW_C2:  low_q[2]  <= pwdata[CH_W-1:0];
        REG_HIGH_C0: high_q[0] <= pwdata[CH_W-1:0];
        REG_HIGH_C1: high_q[1] <= pwdata[CH_W-1:0];
        REG_HIGH_C2: high_q[2] <= pwdata[CH_W-1:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // register readback, zero outside the list
  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_LOW_C0:  prdata[CH_W-1:0] = low_q[0];
      REG_LOW_C1:  prdata[CH_W-1:0] = low_q[1];
      REG_LOW_C2:  prdata[CH_W-1:0] = low_q[2];
      REG_HIGH_C0: prdata[CH_W-1:0] = high_q[0];
      REG_HIGH_C1: prdata[CH_W-1:0] = high_q[1];
      REG_HIGH_C2: prdata[CH_W-1:0] = high_q[2];
      default: ;
    endcase
  end

  assign margin.lo = low_q;
  assign margin.hi = high_q;

  // front end: decode and take the transfer when the queue has room and no sweep runs
  scc_front u_front (
    .pix_i      (pix_i),
    .clearing_i (clearing),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .cmd_o      (q_in)
  );

  scc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  // back end: classify, histogram update, median walk, region store
  scc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .margin_i    (margin),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_ready_i (res_o.ready),
    .clearing_o  (clearing)
  );

  assign res_o.valid       = res_valid;
  assign res_o.result_kind = res.kind;
  assign res_o.pixel_mask  = res.mask;
  assign res_o.median_c0   = res.med[0];
  assign res_o.median_c1   = res.med[1];
  assign res_o.median_c2   = res.med[2];

  // the queue never takes a transfer while full
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("queue push while full");

  // no pixel enters during the histogram sweep after reset
  a_no_accept_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !(pix_i.valid && pix_i.ready))
    else $error("transfer accepted during clearing sweep");

  // a mask result carries zero medians, a median result a zero mask
  a_result_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> ((res.kind == RES_MASK && res.med == '0) ||
                   (res.kind == RES_MEDIAN && !res.mask)))
    else $error("result fields inconsistent with kind");

  // nothing leaves the queue while the sweep is running
  a_no_pop_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !q_pop)
    else $error("queue popped during clearing sweep");

endmodule
